[src/hkb_pkg.sv]
`default_nettype none
package hkb_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int MOD_BITS  = 8;
	localparam int EVT_SLOTS = MOD_BITS + 2 * KEY_SLOTS;
	localparam logic [7:0] MOD_BASE = 8'd224;

	// one report that has at least one event pending
	typedef struct packed {
		logic [EVT_SLOTS-1:0]     mask;
		logic [MOD_BITS-1:0]      mods;
		logic [KEY_SLOTS-1:0][7:0] cur;
		logic [KEY_SLOTS-1:0][7:0] prev;
	} evt_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage
`default_nettype wire

[src/hid_keyboard_report_to_key_events_core.sv]
// data path: report -> queue -> event mask register -> event output register
// throughput: a report is taken every cycle while the 2-entry queue has room;
// the event unit sends one event per cycle while out_stall is low, and holds a report
// until its last event is sent; reports without events are not queued
// reset: stored keys and modifiers clear to zero, queue and output register empty
`default_nettype none
module hid_keyboard_report_to_key_events_core
	import hkb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       report_ok,
	input  wire logic [7:0] modifier_bits,
	input  wire logic [7:0] key_slot0,
	input  wire logic [7:0] key_slot1,
	input  wire logic [7:0] key_slot2,
	input  wire logic [7:0] key_slot3,
	input  wire logic [7:0] key_slot4,
	input  wire logic [7:0] key_slot5,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            key_down,
	output logic [7:0]      scan_code,
	output logic            last_event
);

	fifo_stat_t fifo_stat;
	evt_entry_t push_entry;
	evt_entry_t pop_entry;
	logic       push;
	logic       pop;

	hkb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.report_ok     (report_ok),
		.modifier_bits (modifier_bits),
		.key_slot0     (key_slot0),
		.key_slot1     (key_slot1),
		.key_slot2     (key_slot2),
		.key_slot3     (key_slot3),
		.key_slot4     (key_slot4),
		.key_slot5     (key_slot5),
		.fifo_stat     (fifo_stat),
		.push          (push),
		.push_entry    (push_entry)
	);

	hkb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (fifo_stat)
	);

	hkb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_entry  (pop_entry),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_down   (key_down),
		.scan_code  (scan_code),
		.last_event (last_event)
	);

	// queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !fifo_stat.full)
		else $error("push into full queue");

	// queue never underflows
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	// only reports that cause events are queued
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (push_entry.mask != '0))
		else $error("queued report without events");

	// full and empty are exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.full |-> !fifo_stat.empty)
		else $error("queue both full and empty");

endmodule
`default_nettype wire

[src/hkb_front.sv]
`default_nettype none
module hkb_front
	import hkb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       report_ok,
	input  wire logic [7:0] modifier_bits,
	input  wire logic [7:0] key_slot0,
	input  wire logic [7:0] key_slot1,
	input  wire logic [7:0] key_slot2,
	input  wire logic [7:0] key_slot3,
	input  wire logic [7:0] key_slot4,
	input  wire logic [7:0] key_slot5,
	input  wire fifo_stat_t fifo_stat,
	output logic            push,
	output evt_entry_t      push_entry
);

	logic [KEY_SLOTS-1:0][7:0] prev_keys_q;
	logic [MOD_BITS-1:0]       prev_mods_q;
	logic [KEY_SLOTS-1:0][7:0] cur;
	logic [KEY_SLOTS-1:0]      cur_seen;
	logic [KEY_SLOTS-1:0]      prev_seen;
	logic [EVT_SLOTS-1:0]      mask;
	logic                      accept;

	assign cur = {key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0};

	// each slot is looked up against all six slots of the other report
	always_comb begin
		cur_seen  = '0;
		prev_seen = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (cur[i] == prev_keys_q[j]) begin
					cur_seen[i] = 1'b1;
				end
				if (prev_keys_q[i] == cur[j]) begin
					prev_seen[i] = 1'b1;
				end
			end
		end
	end

	// event order: modifier bits, then press/release pairs per slot
	always_comb begin
		mask[MOD_BITS-1:0] = modifier_bits ^ prev_mods_q;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			mask[MOD_BITS + 2*i]     = (cur[i] != 8'd0) && !cur_seen[i];
			mask[MOD_BITS + 2*i + 1] = (prev_keys_q[i] != 8'd0) && !prev_seen[i];
		end
	end

	assign in_stall = fifo_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && report_ok && (mask != '0);

	assign push_entry.mask = mask;
	assign push_entry.mods = modifier_bits;
	assign push_entry.cur  = cur;
	assign push_entry.prev = prev_keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
			prev_mods_q <= '0;
		end else if (accept) begin
			prev_keys_q <= cur;
			if (report_ok) begin
				prev_mods_q <= modifier_bits;
			end
		end
	end

endmodule
`default_nettype wire

[src/hkb_fifo.sv]
`default_nettype none
module hkb_fifo
	import hkb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire evt_entry_t push_entry,
	input  wire logic       pop,
	output evt_entry_t      pop_entry,
	output fifo_stat_t      stat
);

	localparam int DEPTH = 2;

	evt_entry_t mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_entry  = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == 2'(DEPTH));
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/hkb_back.sv]
`default_nettype none
module hkb_back
	import hkb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire evt_entry_t pop_entry,
	input  wire fifo_stat_t fifo_stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            key_down,
	output logic [7:0]      scan_code,
	output logic            last_event
);

	logic [EVT_SLOTS-1:0]      mask_q;
	logic [MOD_BITS-1:0]       mods_q;
	logic [KEY_SLOTS-1:0][7:0] cur_q;
	logic [KEY_SLOTS-1:0][7:0] prev_q;
	logic                      out_valid_q;
	logic                      down_q;
	logic [7:0]                code_q;
	logic                      last_q;

	logic [EVT_SLOTS-1:0] low;
	logic [EVT_SLOTS-1:0] rest;
	logic                 busy;
	logic                 advance;
	logic                 ev_down;
	logic [7:0]           ev_code;

	assign busy    = (mask_q != '0);
	assign advance = !out_valid_q || !out_stall;
	assign low     = mask_q & (~mask_q + EVT_SLOTS'(1));
	assign rest    = mask_q & ~low;
	assign pop     = !fifo_stat.empty && (!busy || (advance && (rest == '0)));

	always_comb begin
		ev_down = 1'b0;
		ev_code = 8'd0;
		for (int b = 0; b < MOD_BITS; b++) begin
			if (low[b]) begin
				ev_down = mods_q[b];
				ev_code = MOD_BASE + 8'(b);
			end
		end
		for (int s = 0; s < KEY_SLOTS; s++) begin
			if (low[MOD_BITS + 2*s]) begin
				ev_down = 1'b1;
				ev_code = cur_q[s];
			end
			if (low[MOD_BITS + 2*s + 1]) begin
				ev_down = 1'b0;
				ev_code = prev_q[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy;
			end
			// a pop only happens once the current report has no events left
			if (pop) begin
				mask_q <= pop_entry.mask;
			end else if (advance && busy) begin
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mods_q <= pop_entry.mods;
			cur_q  <= pop_entry.cur;
			prev_q <= pop_entry.prev;
		end
		if (advance && busy) begin
			down_q <= ev_down;
			code_q <= ev_code;
			last_q <= (rest == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign key_down   = down_q;
	assign scan_code  = code_q;
	assign last_event = last_q;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
	import hkb_pkg::*;

	typedef logic [KEY_SLOTS-1:0][7:0] key_set_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] mods;
		key_set_t   keys;
	} kbd_report_t;

	typedef struct packed {
		logic       down;
		logic [7:0] code;
		logic       last;
	} key_event_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       report_ok;
	logic [7:0] modifier_bits;
	logic [7:0] key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5;
	logic       out_valid;
	logic       out_stall;
	logic       key_down;
	logic [7:0] scan_code;
	logic       last_event;

	// predictor state: what the block should hold after the last accepted report
	key_set_t    held_keys;
	logic [7:0]  held_mods;
	key_event_t  expected_events[$];
	kbd_report_t last_sent;

	int mismatch_count  = 0;
	int events_checked  = 0;
	int reports_sent    = 0;
	int reports_dropped = 0;
	int modifier_events = 0;
	bit sender_gaps     = 1'b1;
	bit receiver_stalls = 1'b1;

	hid_keyboard_report_to_key_events_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.report_ok    (report_ok),
		.modifier_bits(modifier_bits),
		.key_slot0    (key_slot0),
		.key_slot1    (key_slot1),
		.key_slot2    (key_slot2),
		.key_slot3    (key_slot3),
		.key_slot4    (key_slot4),
		.key_slot5    (key_slot5),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_down     (key_down),
		.scan_code    (scan_code),
		.last_event   (last_event)
	);

	always #2 clk = ~clk;

	function automatic bit key_present(input key_set_t set, input logic [7:0] k);
		for (int s = 0; s < KEY_SLOTS; s++)
			if (set[s] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	task automatic predict_key_events(input kbd_report_t r);
		key_event_t evts[$];
		key_event_t e;
		logic [7:0] changed;
		if (r.ok) begin
			changed = r.mods ^ held_mods;
			for (int b = 0; b < MOD_BITS; b++)
				if (changed[b]) begin
					e.down = r.mods[b];
					e.code = MOD_BASE + 8'(b);
					e.last = 1'b0;
					evts.push_back(e);
					modifier_events++;
				end
			held_mods = r.mods;
			for (int s = 0; s < KEY_SLOTS; s++) begin
				if (r.keys[s] != 8'd0 && !key_present(held_keys, r.keys[s])) begin
					e.down = 1'b1;
					e.code = r.keys[s];
					e.last = 1'b0;
					evts.push_back(e);
				end
				if (held_keys[s] != 8'd0 && !key_present(r.keys, held_keys[s])) begin
					e.down = 1'b0;
					e.code = held_keys[s];
					e.last = 1'b0;
					evts.push_back(e);
				end
			end
			if (evts.size() > 0)
				evts[evts.size()-1].last = 1'b1;
			foreach (evts[i])
				expected_events.push_back(evts[i]);
		end else begin
			reports_dropped++;
		end
		// keys follow every report, modifiers only ok ones
		held_keys = r.keys;
	endtask

	// sends one report item and predicts its events on acceptance
	task automatic send_report(input kbd_report_t r);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid      = 1'b1;
		report_ok     = r.ok;
		modifier_bits = r.mods;
		key_slot0     = r.keys[0];
		key_slot1     = r.keys[1];
		key_slot2     = r.keys[2];
		key_slot3     = r.keys[3];
		key_slot4     = r.keys[4];
		key_slot5     = r.keys[5];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_key_events(r);
		last_sent = r;
		reports_sent++;
		@(negedge clk);
	endtask

	function automatic kbd_report_t make_report(input logic ok, input logic [7:0] mods,
			input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
			input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
		kbd_report_t r;
		r.ok   = ok;
		r.mods = mods;
		r.keys = {k5, k4, k3, k2, k1, k0};
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		key_event_t exp_evt;
		if (arst_n && out_valid && !out_stall) begin
			events_checked++;
			if (expected_events.size() == 0) begin
				flag_error($sformatf("unexpected event down=%0b code=%0d last=%0b",
					key_down, scan_code, last_event));
			end else begin
				exp_evt = expected_events.pop_front();
				if (key_down !== exp_evt.down || scan_code !== exp_evt.code ||
						last_event !== exp_evt.last)
					flag_error($sformatf({"event mismatch: expected down=%0b code=%0d",
						" last=%0b, got down=%0b code=%0d last=%0b"},
						exp_evt.down, exp_evt.code, exp_evt.last,
						key_down, scan_code, last_event));
			end
		end
	end

	// receiver back-pressure in bursts, with quiet stretches in between
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	task automatic test_directed();
		send_report(make_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		// every modifier flips, six new keys and six released: the largest burst
		send_report(make_report(1'b1, 8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
		send_report(make_report(1'b1, 8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
		// failed transfer: keys still latch, modifiers do not
		send_report(make_report(1'b0, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
		// one keycode repeated in every slot
		send_report(make_report(1'b1, 8'h55, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
		send_report(make_report(1'b1, 8'hAA, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'hAA, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// same keys in another slot order
		send_report(make_report(1'b1, 8'h01, 8'h1E, 8'h1F, 8'h20, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'h01, 8'h00, 8'h20, 8'h1F, 8'h1E, 8'h00, 8'h00));
		send_report(make_report(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(make_report(1'b1, 8'h80, 8'hFF, 8'hFE, 8'h7F, 8'h01, 8'h02, 8'h03));
		send_report(make_report(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// mostly plausible typing, some repeats and failed transfers, some raw noise
	task automatic test_random_typing(input int count);
		logic [7:0]  pressed[$];
		logic [7:0]  mods;
		logic [7:0]  k;
		kbd_report_t r;
		int          pick;
		mods = 8'h00;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (pressed.size() < KEY_SLOTS &&
						(pressed.size() == 0 || $urandom_range(0, 1))) begin
					k = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
						: 8'($urandom_range(4, 231));
					pressed.push_back(k);
				end else if (pressed.size() > 0) begin
					pressed.delete($urandom_range(0, pressed.size() - 1));
				end
				if ($urandom_range(0, 3) == 0)
					mods[$urandom_range(0, 7)] ^= 1'b1;
				r.ok   = ($urandom_range(0, 19) != 0);
				r.mods = mods;
				r.keys = '0;
				foreach (pressed[i])
					r.keys[i] = pressed[i];
				// occasionally shuffle slot positions
				if ($urandom_range(0, 7) == 0)
					for (int s = 0; s < KEY_SLOTS; s++) begin
						k = r.keys[s];
						pick = $urandom_range(0, KEY_SLOTS - 1);
						r.keys[s] = r.keys[pick];
						r.keys[pick] = k;
					end
			end else if (pick < 85) begin
				r = last_sent;
				r.ok = 1'($urandom_range(0, 1));
			end else begin
				r.ok   = 1'($urandom_range(0, 1));
				r.mods = 8'($urandom);
				for (int s = 0; s < KEY_SLOTS; s++)
					r.keys[s] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
			end
			send_report(r);
		end
	endtask

	task automatic test_pause_for_drain();
		test_random_typing(10);
		in_valid = 1'b0;
		while (expected_events.size() != 0)
			@(negedge clk);
		test_random_typing(10);
	endtask

	task automatic test_steady_stream();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		test_random_typing(60);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		report_ok     = 1'b0;
		modifier_bits = 8'h00;
		key_slot0     = 8'h00;
		key_slot1     = 8'h00;
		key_slot2     = 8'h00;
		key_slot3     = 8'h00;
		key_slot4     = 8'h00;
		key_slot5     = 8'h00;
		held_keys     = '0;
		held_mods     = 8'h00;
		last_sent     = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_typing(180);
		test_pause_for_drain();
		test_random_typing(150);
		test_steady_stream();

		in_valid = 1'b0;
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (expected_events.size() != 0)
			flag_error($sformatf("%0d events never arrived", expected_events.size()));
		if (mismatch_count > 10)
			$display("%0d further mismatches not shown", mismatch_count - 10);

		$display("run: %0d reports (%0d failed transfers), %0d events checked",
			reports_sent, reports_dropped, events_checked);
		$display("     %0d modifier events, stalls on both sides then a steady stream",
			modifier_events);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout: run did not finish");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[hid_keyboard_report_to_key_events_core.f]
src/hkb_pkg.sv
src/hkb_front.sv
src/hkb_fifo.sv
src/hkb_back.sv
src/hid_keyboard_report_to_key_events_core.sv
tb/tb.sv
